// ----- hdl/cssh_pkg.sv -----
// shared types, constants and helpers of the call-site sample histogram
// no dependencies; every other file of the block but cssh_ram imports this package
package cssh_pkg;

  localparam int unsigned SYMBOLS_DEF = 4096;
  localparam int unsigned BINS_DEF    = 256;
  localparam int unsigned TOP_N_DEF   = 30;
  localparam int unsigned QUEUE_DEF   = 2;

  localparam int unsigned IDX_W  = 12;
  localparam int unsigned CNTR_W = 13;

  localparam logic [31:0] GAP_LIMIT  = 32'h0001_0000;
  localparam logic [31:0] SITE_WRITE = 32'hCC00_8000;
  localparam logic [31:0] SITE_BURST = 32'hCC00_8001;
  localparam logic [31:0] SAT_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_REPORT = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CLASS_FOUND = 2'd0,
    CLASS_NONE  = 2'd1,
    CLASS_WRITE = 2'd2,
    CLASS_BURST = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_ZERO   = 3'd1,
    CMD_KEY    = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_REPORT = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] entry_index;
    logic [31:0]      entry_address;
    logic [31:0]      return_address;
    logic [7:0]       host_phase;
    logic [31:0]      native_site;
  } in_item_t;

  typedef struct packed {
    logic             entry_valid;
    logic [7:0]       bin_phase;
    logic             is_native;
    logic [1:0]       site_class;
    logic [IDX_W-1:0] symbol_index;
    logic [31:0]      bin_count;
    logic [31:0]      total_samples;
    logic [31:0]      zero_samples;
    logic [31:0]      dropped_samples;
    logic             last;
  } out_item_t;

  // bin key: phase, native flag, class, symbol slot
  typedef struct packed {
    logic [7:0]       phase;
    logic             native;
    class_e           cls;
    logic [IDX_W-1:0] idx;
  } key_t;

  // command handed from the front to the back
  typedef struct packed {
    cmd_e             op;
    logic             native;
    class_e           cls;
    logic [7:0]       phase;
    logic [31:0]      addr;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == SAT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

// ----- hdl/cssh_if.sv -----
// valid/ready channel interfaces of the call-site sample histogram
// depends on cssh_pkg for the beat payload types
interface cssh_in_if import cssh_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cssh_out_if import cssh_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cssh_cfg_if import cssh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CNTR_W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/cssh_ram.sv -----
// generic single-write, single-read ram with registered read data
// no package dependencies
module cssh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/cssh_front.sv -----
// front end: accepts input beats and classifies them into back-end commands
// depends on cssh_pkg and cssh_if
module cssh_front import cssh_pkg::*; #(
  parameter int unsigned SYMBOLS = SYMBOLS_DEF
) (
  cssh_in_if.sink in_i,
  output logic    push_valid_o,
  input  logic    push_ready_i,
  output cmd_t    push_data_o
);

  logic keep;
  cmd_t cmd;

  always_comb begin
    keep        = 1'b0;
    cmd.op      = CMD_LOAD;
    cmd.native  = 1'b0;
    cmd.cls     = CLASS_NONE;
    cmd.phase   = in_i.data.host_phase;
    cmd.addr    = in_i.data.entry_address;
    cmd.idx     = in_i.data.entry_index;
    case (action_e'(in_i.data.action))
      ACT_LOAD: begin
        // loads beyond the table are dropped here
        keep = (32'(in_i.data.entry_index) < 32'(SYMBOLS));
      end
      ACT_SAMPLE: begin
        keep = 1'b1;
        if (in_i.data.return_address == 32'd0) begin
          cmd.op = CMD_ZERO;
        end else if (in_i.data.native_site == SITE_WRITE) begin
          cmd.op     = CMD_KEY;
          cmd.native = 1'b1;
          cmd.cls    = CLASS_WRITE;
        end else if (in_i.data.native_site == SITE_BURST) begin
          cmd.op     = CMD_KEY;
          cmd.native = 1'b1;
          cmd.cls    = CLASS_BURST;
        end else if (in_i.data.native_site != 32'd0) begin
          cmd.op     = CMD_SEARCH;
          cmd.native = 1'b1;
          cmd.addr   = in_i.data.native_site;
        end else begin
          cmd.op   = CMD_SEARCH;
          cmd.addr = in_i.data.return_address;
        end
      end
      ACT_REPORT: begin
        keep   = 1'b1;
        cmd.op = CMD_REPORT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid & keep;
  assign push_data_o  = cmd;

endmodule

// ----- hdl/cssh_queue.sv -----
// short command queue between front and back
// depends on cssh_pkg for the command type
module cssh_queue import cssh_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEF,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  cmd_t          slot_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] fill_q;
  logic          push, pop;

  assign push_ready_o = (fill_q != CW'(DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = slot_q[rptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= (32'(rptr_q) == DEPTH - 1) ? '0 : rptr_q + PW'(1);
      end
      fill_q <= fill_q + CW'(push) - CW'(pop);
    end
  end

endmodule

// ----- hdl/cssh_back.sv -----
// back end: table search, bin update and top-n report sequencer
// depends on cssh_pkg, cssh_if and cssh_ram
module cssh_back import cssh_pkg::*; #(
  parameter int unsigned SYMBOLS = SYMBOLS_DEF,
  parameter int unsigned BINS    = BINS_DEF,
  parameter int unsigned TOP_N   = TOP_N_DEF,
  localparam int unsigned SAW    = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1,
  localparam int unsigned CW     = $clog2(SYMBOLS + 1),
  localparam int unsigned BAW    = $clog2(BINS),
  localparam int unsigned UW     = $clog2(BINS + 1),
  localparam int unsigned KW     = $clog2(TOP_N + 1),
  localparam int unsigned KEY_W  = $bits(key_t)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cssh_cfg_if.sink    cfg_i,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  cmd_t        pop_data_i,
  cssh_out_if.source  out_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SRCH = 8'b0000_0010,
    ST_SCMP = 8'b0000_0100,
    ST_BIN  = 8'b0000_1000,
    ST_BCMP = 8'b0001_0000,
    ST_RRD  = 8'b0010_0000,
    ST_RCMP = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CNTR_W-1:0] sym_cnt_q;
  cmd_t              cmd_q, cmd_d;
  logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d, fidx_q, fidx_d;
  logic [31:0]       fval_q, fval_d;
  logic              hit_q, hit_d;
  key_t              key_q, key_d;
  logic [UW-1:0]     i_q, i_d, used_q, used_d;
  logic [31:0]       total_q, total_d, zero_q, zero_d, drop_q, drop_d;
  logic [31:0]       best_cnt_q, best_cnt_d, prev_cnt_q, prev_cnt_d;
  key_t              best_key_q, best_key_d;
  logic [UW-1:0]     best_i_q, best_i_d, prev_i_q, prev_i_d;
  logic              have_best_q, have_best_d, have_prev_q, have_prev_d;
  logic [KW-1:0]     k_q, k_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [CW-1:0]     n_sym, mid;
  logic [31:0]       sym_rdata, cnt_rdata;
  logic [KEY_W-1:0]  key_rdata;
  key_t              rkey;
  logic              sym_we, key_we, cnt_we;
  logic [31:0]       cnt_wdata;
  logic [BAW-1:0]    bin_waddr;
  logic              elig, is_last;

  assign n_sym = (32'(sym_cnt_q) > SYMBOLS) ? CW'(SYMBOLS) : CW'(sym_cnt_q);
  assign mid   = CW'((32'(lo_q) + 32'(hi_q)) >> 1);
  assign rkey  = key_t'(key_rdata);

  cssh_ram #(.WIDTH(32), .DEPTH(SYMBOLS)) u_sym_ram (
    .clk_i  (clk_i),
    .we_i   (sym_we),
    .waddr_i(SAW'(pop_data_i.idx)),
    .wdata_i(pop_data_i.addr),
    .raddr_i(mid[SAW-1:0]),
    .rdata_o(sym_rdata)
  );

  cssh_ram #(.WIDTH(KEY_W), .DEPTH(BINS)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(bin_waddr),
    .wdata_i(key_q),
    .raddr_i(i_q[BAW-1:0]),
    .rdata_o(key_rdata)
  );

  cssh_ram #(.WIDTH(32), .DEPTH(BINS)) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(bin_waddr),
    .wdata_i(cnt_wdata),
    .raddr_i(i_q[BAW-1:0]),
    .rdata_o(cnt_rdata)
  );

  assign cfg_i.ready = 1'b1;
  assign pop_ready_o = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // bin i is still eligible if it ranks after the previously reported bin
  assign elig = !have_prev_q || (cnt_rdata < prev_cnt_q) ||
                ((cnt_rdata == prev_cnt_q) && (i_q > prev_i_q));
  assign is_last = (32'(k_q) + 32'd1 == TOP_N) || (32'(k_q) + 32'd1 == 32'(used_q));

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    fidx_d      = fidx_q;
    fval_d      = fval_q;
    hit_d       = hit_q;
    key_d       = key_q;
    i_d         = i_q;
    used_d      = used_q;
    total_d     = total_q;
    zero_d      = zero_q;
    drop_d      = drop_q;
    best_cnt_d  = best_cnt_q;
    best_key_d  = best_key_q;
    best_i_d    = best_i_q;
    have_best_d = have_best_q;
    prev_cnt_d  = prev_cnt_q;
    prev_i_d    = prev_i_q;
    have_prev_d = have_prev_q;
    k_d         = k_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    sym_we      = 1'b0;
    key_we      = 1'b0;
    cnt_we      = 1'b0;
    cnt_wdata   = 32'd1;
    bin_waddr   = used_q[BAW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          cmd_d = pop_data_i;
          i_d   = '0;
          case (pop_data_i.op)
            CMD_LOAD: begin
              sym_we = 1'b1;
            end
            CMD_ZERO: begin
              total_d = sat_inc(total_q);
              zero_d  = sat_inc(zero_q);
            end
            CMD_KEY: begin
              total_d = sat_inc(total_q);
              key_d   = '{phase: pop_data_i.phase, native: pop_data_i.native,
                          cls: pop_data_i.cls, idx: '0};
              state_d = ST_BIN;
            end
            CMD_SEARCH: begin
              total_d = sat_inc(total_q);
              lo_d    = '0;
              hi_d    = n_sym;
              hit_d   = 1'b0;
              state_d = ST_SRCH;
            end
            CMD_REPORT: begin
              k_d         = '0;
              have_prev_d = 1'b0;
              have_best_d = 1'b0;
              state_d     = (used_q == '0) ? ST_EMIT : ST_RRD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SRCH: begin
        if (lo_q < hi_q) begin
          state_d = ST_SCMP;
        end else begin
          key_d.phase  = cmd_q.phase;
          key_d.native = cmd_q.native;
          if (hit_q && ((cmd_q.addr - fval_q) < GAP_LIMIT)) begin
            key_d.cls = CLASS_FOUND;
            key_d.idx = IDX_W'(fidx_q);
          end else begin
            key_d.cls = CLASS_NONE;
            key_d.idx = '0;
          end
          state_d = ST_BIN;
        end
      end
      ST_SCMP: begin
        if (sym_rdata <= cmd_q.addr) begin
          lo_d   = mid + CW'(1);
          hit_d  = 1'b1;
          fval_d = sym_rdata;
          fidx_d = mid;
        end else begin
          hi_d = mid;
        end
        state_d = ST_SRCH;
      end
      ST_BIN: begin
        if (i_q < used_q) begin
          state_d = ST_BCMP;
        end else begin
          if (32'(used_q) < BINS) begin
            key_we = 1'b1;
            cnt_we = 1'b1;
            used_d = used_q + UW'(1);
          end else begin
            drop_d = sat_inc(drop_q);
          end
          state_d = ST_IDLE;
        end
      end
      ST_BCMP: begin
        if (rkey == key_q) begin
          cnt_we    = 1'b1;
          cnt_wdata = sat_inc(cnt_rdata);
          bin_waddr = i_q[BAW-1:0];
          state_d   = ST_IDLE;
        end else begin
          i_d     = i_q + UW'(1);
          state_d = ST_BIN;
        end
      end
      ST_RRD: begin
        state_d = ST_RCMP;
      end
      ST_RCMP: begin
        if (elig && (!have_best_q || (cnt_rdata > best_cnt_q))) begin
          best_cnt_d  = cnt_rdata;
          best_key_d  = rkey;
          best_i_d    = i_q;
          have_best_d = 1'b1;
        end
        i_d     = i_q + UW'(1);
        state_d = (i_q + UW'(1) == used_q) ? ST_EMIT : ST_RRD;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d           = 1'b1;
          out_d.total_samples   = total_q;
          out_d.zero_samples    = zero_q;
          out_d.dropped_samples = drop_q;
          if (used_q == '0) begin
            out_d.entry_valid  = 1'b0;
            out_d.bin_phase    = '0;
            out_d.is_native    = 1'b0;
            out_d.site_class   = '0;
            out_d.symbol_index = '0;
            out_d.bin_count    = '0;
            out_d.last         = 1'b1;
          end else begin
            out_d.entry_valid  = 1'b1;
            out_d.bin_phase    = best_key_q.phase;
            out_d.is_native    = best_key_q.native;
            out_d.site_class   = best_key_q.cls;
            out_d.symbol_index = (best_key_q.cls == CLASS_FOUND) ? best_key_q.idx : '0;
            out_d.bin_count    = best_cnt_q;
            out_d.last         = is_last;
          end
          if ((used_q == '0) || is_last) begin
            used_d  = '0;
            total_d = '0;
            zero_d  = '0;
            drop_d  = '0;
            state_d = ST_IDLE;
          end else begin
            prev_cnt_d  = best_cnt_q;
            prev_i_d    = best_i_q;
            have_prev_d = 1'b1;
            have_best_d = 1'b0;
            i_d         = '0;
            k_d         = k_q + KW'(1);
            state_d     = ST_RRD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sym_cnt_q   <= '0;
      used_q      <= '0;
      total_q     <= '0;
      zero_q      <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
      have_best_q <= 1'b0;
      have_prev_q <= 1'b0;
      hit_q       <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
    end else begin
      state_q     <= state_d;
      if (cfg_i.valid) begin
        sym_cnt_q <= cfg_i.data;
      end
      used_q      <= used_d;
      total_q     <= total_d;
      zero_q      <= zero_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      have_best_q <= have_best_d;
      have_prev_q <= have_prev_d;
      hit_q       <= hit_d;
      i_q         <= i_d;
      k_q         <= k_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    fidx_q     <= fidx_d;
    fval_q     <= fval_d;
    key_q      <= key_d;
    best_cnt_q <= best_cnt_d;
    best_key_q <= best_key_d;
    best_i_q   <= best_i_d;
    prev_cnt_q <= prev_cnt_d;
    prev_i_q   <= prev_i_d;
    out_q      <= out_d;
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= BINS)
    else $error("bin fill count beyond bin count");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH) |-> (lo_q <= hi_q))
    else $error("search window crossed");

  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result beat raised outside emit");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_BIN) && !(i_q < used_q) && (32'(used_q) != BINS))
      |=> (drop_q == $past(drop_q)))
    else $error("sample dropped while a bin was free");

endmodule

// ----- hdl/call_site_sample_histogram_top.sv -----
// Call-site sample histogram. A load beat writes one function start address into the
// sorted symbol table, a sample beat with a nonzero return address counts that address
// (or its native site) into a bin keyed by host phase, native flag, class and symbol
// slot, and a report beat returns up to TOP_N bins by descending count (ties to the
// lower bin slot), the last beat flagged, and then clears all bins and counters; an
// empty report returns one beat with entry_valid low. The front takes a beat per cycle
// while the queue has room into a QUEUE_DEF-deep command queue, and the back runs one
// command at a time. A load or zero-address sample is done at dispatch, a sample with a
// fixed gather-pipe class scans the occupied bins for its key, and a searched sample
// first runs the floor search on the symbol ram and then the key scan. A report rescans
// all bins in use for each returned bin, one bin at a time through the single read port
// of the bin rams. No clearing pass is needed after reset; the bin fill count marks the
// live part of the bin rams.
// depends on cssh_pkg, cssh_if, cssh_ram, cssh_front, cssh_queue and cssh_back
module call_site_sample_histogram_top import cssh_pkg::*; #(
  parameter int unsigned SYMBOLS = SYMBOLS_DEF,
  parameter int unsigned BINS    = BINS_DEF,
  parameter int unsigned TOP_N   = TOP_N_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cssh_in_if.sink     in_i,
  cssh_cfg_if.sink    cfg_i,
  cssh_out_if.source  out_o
);

  // front to queue
  logic push_valid, push_ready;
  cmd_t push_data;
  // queue to back
  logic pop_valid, pop_ready;
  cmd_t pop_data;

  // decode each input beat into a command, dropping what needs no work
  cssh_front #(.SYMBOLS(SYMBOLS)) u_front (
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  // short queue so the front keeps taking beats while the back is busy
  cssh_queue #(.DEPTH(QUEUE_DEF)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  // table search, bin update and report, with a registered result beat
  cssh_back #(
    .SYMBOLS(SYMBOLS),
    .BINS   (BINS),
    .TOP_N  (TOP_N)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_o      (out_o)
  );

endmodule

// ----- verif/tb_chan_if.sv -----
`timescale 1ns / 100ps
// note: the block's own interfaces (cssh_in_if, cssh_out_if, cssh_cfg_if) serve as the
// testbench channels; this file holds the beat record kept by the monitor
// depends on cssh_pkg for the beat payload types
package tb_beat_pkg;
  import cssh_pkg::*;

  // one expected report beat
  typedef out_item_t report_beat_t;
endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// testbench of the call-site sample histogram: loads symbol tables, streams samples
// and reports, predicts every report beat and compares each received beat with it as a whole
// depends on cssh_pkg, tb_beat_pkg, cssh_if and call_site_sample_histogram_top
module tb_top;
  import cssh_pkg::*;
  import tb_beat_pkg::*;

  localparam int unsigned NSYM  = SYMBOLS_DEF;
  localparam int unsigned NBIN  = BINS_DEF;
  localparam int unsigned NTOP  = TOP_N_DEF;
  localparam longint LIMIT_CYCLES = 64'd3_000_000;

  logic clk_i;
  logic rst_ni;

  cssh_in_if  in_ch ();
  cssh_cfg_if cfg_ch ();
  cssh_out_if out_ch ();

  call_site_sample_histogram_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  // mirror of the block state
  logic [31:0] sym_starts [NSYM];
  logic [22:0] hist_keys [NBIN];
  logic [31:0] hist_counts [NBIN];
  int unsigned hist_used;
  logic [31:0] tot_samples, zero_cnt, drop_cnt;
  logic [12:0] sym_count;

  in_item_t     pending_beats [$];
  report_beat_t expected_reports [$];

  int unsigned mismatches;
  longint      cycle_cnt;
  bit          tail_phase;
  bit          hold_off_req;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sat_up(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // floor search over the loaded table, returns slot or -1
  function automatic int floor_slot(input logic [31:0] addr);
    int unsigned n, lo, hi, mid;
    n = (sym_count > NSYM) ? NSYM : sym_count;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (sym_starts[mid] <= addr) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) return -1;
    if (addr - sym_starts[lo-1] >= GAP_LIMIT) return -1;
    return lo - 1;
  endfunction

  function automatic logic [22:0] build_key(input logic [7:0] ph, input logic nat,
                                            input class_e c, input logic [11:0] ix);
    return {ph, nat, c, ix};
  endfunction

  // advance the mirror by one accepted beat; queue expected report beats
  task automatic predict_beat(input in_item_t b);
    logic [22:0] k;
    int s, best, want, used;
    bit hit, have;
    bit marks [NBIN];
    report_beat_t r;
    case (b.action)
      ACT_LOAD: sym_starts[b.entry_index] = b.entry_address;
      ACT_SAMPLE: begin
        tot_samples = sat_up(tot_samples);
        if (b.return_address == 32'd0) begin
          zero_cnt = sat_up(zero_cnt);
        end else begin
          if (b.native_site == SITE_WRITE) begin
            k = build_key(b.host_phase, 1'b1, CLASS_WRITE, 12'd0);
          end else if (b.native_site == SITE_BURST) begin
            k = build_key(b.host_phase, 1'b1, CLASS_BURST, 12'd0);
          end else if (b.native_site != 32'd0) begin
            s = floor_slot(b.native_site);
            k = (s < 0) ? build_key(b.host_phase, 1'b1, CLASS_NONE, 12'd0)
                        : build_key(b.host_phase, 1'b1, CLASS_FOUND, s[11:0]);
          end else begin
            s = floor_slot(b.return_address);
            k = (s < 0) ? build_key(b.host_phase, 1'b0, CLASS_NONE, 12'd0)
                        : build_key(b.host_phase, 1'b0, CLASS_FOUND, s[11:0]);
          end
          hit = 0;
          for (int i = 0; i < hist_used; i++) begin
            if (!hit && hist_keys[i] == k) begin
              hist_counts[i] = sat_up(hist_counts[i]);
              hit = 1;
            end
          end
          if (!hit) begin
            if (hist_used < NBIN) begin
              hist_keys[hist_used] = k;
              hist_counts[hist_used] = 32'd1;
              hist_used++;
            end else begin
              drop_cnt = sat_up(drop_cnt);
            end
          end
        end
      end
      ACT_REPORT: begin
        used = hist_used;
        want = (used < NTOP) ? used : NTOP;
        foreach (marks[i]) marks[i] = 0;
        if (want == 0) begin
          r = '0;
          r.total_samples = tot_samples;
          r.zero_samples = zero_cnt;
          r.dropped_samples = drop_cnt;
          r.last = 1'b1;
          expected_reports.push_back(r);
        end else begin
          for (int n = 0; n < want; n++) begin
            best = 0;
            have = 0;
            for (int i = 0; i < used; i++) begin
              if (!marks[i] && (!have || hist_counts[i] > hist_counts[best])) begin
                best = i;
                have = 1;
              end
            end
            marks[best] = 1;
            r.entry_valid = 1'b1;
            r.bin_phase = hist_keys[best][22:15];
            r.is_native = hist_keys[best][14];
            r.site_class = hist_keys[best][13:12];
            r.symbol_index = (hist_keys[best][13:12] == CLASS_FOUND) ?
                             hist_keys[best][11:0] : 12'd0;
            r.bin_count = hist_counts[best];
            r.total_samples = tot_samples;
            r.zero_samples = zero_cnt;
            r.dropped_samples = drop_cnt;
            r.last = (n + 1 == want);
            expected_reports.push_back(r);
          end
        end
        hist_used = 0;
        tot_samples = 0;
        zero_cnt = 0;
        drop_cnt = 0;
      end
      default: ;
    endcase
  endtask

  // driver: offers queued beats, idles in random bursts
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_beat(in_ch.data);
      if (in_ch.valid && !in_ch.ready) begin
        // hold the beat
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        if (!tail_phase && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 16) - 1;
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.data <= pending_beats.pop_front();
          in_ch.valid <= 1'b1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted once on request
  int unsigned hold_cnt;
  bit          hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_off_req && !hold_done) begin
      if (hold_cnt == 3000) hold_done <= 1'b1;
      else hold_cnt <= hold_cnt + 1;
    end
  end

  // monitor and receiver stalls
  int unsigned out_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
      mismatches = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected report beat %p", out_ch.data);
        end else begin
          report_beat_t e;
          e = expected_reports.pop_front();
          if (out_ch.data !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("report beat mismatch: expected %p got %p",
                                           e, out_ch.data);
          end
        end
      end
      if (hold_off_req && !hold_done) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 16) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_item_t mk_load(input int ix, input logic [31:0] a);
    in_item_t b;
    b = '0;
    b.action = ACT_LOAD;
    b.entry_index = ix[11:0];
    b.entry_address = a;
    return b;
  endfunction

  function automatic in_item_t mk_sample(input logic [31:0] ra, input logic [7:0] ph,
                                         input logic [31:0] site);
    in_item_t b;
    b = '0;
    b.action = ACT_SAMPLE;
    b.return_address = ra;
    b.host_phase = ph;
    b.native_site = site;
    // junk in fields the action does not use
    b.entry_index = 12'($urandom);
    b.entry_address = $urandom;
    return b;
  endfunction

  function automatic in_item_t mk_report();
    in_item_t b;
    b = '0;
    b.action = ACT_REPORT;
    b.return_address = $urandom;
    return b;
  endfunction

  // wait for all queued beats and reports, then let the back drain
  task automatic drain_all();
    while (pending_beats.size() > 0 || in_ch.valid || expected_reports.size() > 0)
      @(posedge clk_i);
    repeat (20000) @(posedge clk_i);
  endtask

  task automatic write_symbol_count(input logic [12:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    sym_count = v;
  endtask

  // pick an address near a loaded start, or anywhere
  function automatic logic [31:0] pick_addr(input int n);
    int s;
    if (n == 0 || $urandom_range(0, 3) == 0) return $urandom;
    s = $urandom_range(0, n - 1);
    case ($urandom_range(0, 3))
      0: return sym_starts[s];
      1: return sym_starts[s] + $urandom_range(0, 32'hFFFF);
      2: return sym_starts[s] + 32'h1_0000 + $urandom_range(0, 255);
      default: return sym_starts[s] - 1;
    endcase
  endfunction

  // load a sorted table of n entries starting at base with random strides
  task automatic queue_table(input int n, input logic [31:0] base);
    logic [31:0] a;
    a = base;
    for (int i = 0; i < n; i++) begin
      pending_beats.push_back(mk_load(i, a));
      sym_starts[i] = a;
      a = a + $urandom_range(1, 32'h3_0000);
    end
  endtask

  initial begin
    int n;
    in_item_t b;
    logic [31:0] site;
    tail_phase = 0;
    hold_off_req = 0;
    cycle_cnt = 0;
    hist_used = 0;
    tot_samples = 0;
    zero_cnt = 0;
    drop_cnt = 0;
    sym_count = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    foreach (sym_starts[i]) sym_starts[i] = 0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, zero samples, gather-pipe sites, empty report, action 3
    pending_beats.push_back(mk_report());
    pending_beats.push_back(mk_sample(32'd0, 8'hFF, 32'd0));
    pending_beats.push_back(mk_sample(32'hFFFF_FFFF, 8'h00, 32'd0));
    pending_beats.push_back(mk_sample(32'h8000_0000, 8'hFF, SITE_WRITE));
    pending_beats.push_back(mk_sample(32'h1, 8'h55, SITE_BURST));
    pending_beats.push_back(mk_sample(32'h1, 8'hAA, 32'hFFFF_FFFF));
    b = mk_report();
    b.action = 2'd3;
    pending_beats.push_back(b);
    pending_beats.push_back(mk_load(4095, 32'hFFFF_FFFF));
    pending_beats.push_back(mk_report());
    drain_all();

    // directed: small table with extremes, gap edge and native floor
    write_symbol_count(13'd3);
    pending_beats.push_back(mk_load(0, 32'h0000_0000));
    pending_beats.push_back(mk_load(1, 32'h7FFF_FFFC));
    pending_beats.push_back(mk_load(2, 32'hFFFF_0000));
    sym_starts[0] = 0; sym_starts[1] = 32'h7FFF_FFFC; sym_starts[2] = 32'hFFFF_0000;
    pending_beats.push_back(mk_sample(32'h0000_FFFF, 8'd1, 32'd0));
    pending_beats.push_back(mk_sample(32'h0001_0000, 8'd1, 32'd0));
    pending_beats.push_back(mk_sample(32'hFFFF_FFFF, 8'd2, 32'd0));
    pending_beats.push_back(mk_sample(32'h1, 8'd2, 32'h7FFF_FFFD));
    pending_beats.push_back(mk_sample(32'h1, 8'd2, 32'h7FFF_FFFE));
    pending_beats.push_back(mk_sample(32'h1, 8'd3, 32'h8000_0000));
    pending_beats.push_back(mk_report());
    drain_all();

    // random phases over several table sizes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: n = 0;
        1: n = 1;
        2: n = $urandom_range(2, 20);
        3: n = 48;
        4: n = $urandom_range(20, 40);
        default: n = $urandom_range(2, 12);
      endcase
      if (ph == 3) queue_table(n, $urandom_range(0, 255));
      else queue_table(n, $urandom);
      // the table may not wrap; keep the count only for entries still ascending
      for (int i = 1; i < n; i++)
        if (sym_starts[i] < sym_starts[i-1]) begin
          n = i;
          break;
        end
      drain_all();
      write_symbol_count(n[12:0]);
      if (ph == 3) hold_off_req = 1;
      if (ph == 5) tail_phase = 1;
      for (int j = 0; j < 18; j++) begin
        if ($urandom_range(0, 14) == 0 || (ph == 3 && j == 2)) begin
          pending_beats.push_back(mk_report());
        end else begin
          case ($urandom_range(0, 9))
            0: site = SITE_WRITE;
            1: site = SITE_BURST;
            2, 3: site = pick_addr(n);
            default: site = 32'd0;
          endcase
          pending_beats.push_back(mk_sample(($urandom_range(0, 19) == 0) ? 32'd0 :
                                            pick_addr(n), 8'($urandom_range(0, 3) == 0 ?
                                            $urandom : $urandom_range(0, 3)), site));
        end
      end
      pending_beats.push_back(mk_report());
      drain_all();
    end

    // bins full: many distinct phase keys overflow the bins
    for (int j = 0; j < 260; j++)
      pending_beats.push_back(mk_sample(32'h1, j[7:0], (j < 256) ? SITE_WRITE : SITE_BURST));
    pending_beats.push_back(mk_report());
    drain_all();

    // write an out-of-range symbol count, which the back clamps to SYMBOLS, then zero
    write_symbol_count(13'h1FFF);
    write_symbol_count(13'd0);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/cssh_pkg.sv
hdl/cssh_if.sv
hdl/cssh_ram.sv
hdl/cssh_front.sv
hdl/cssh_queue.sv
hdl/cssh_back.sv
hdl/call_site_sample_histogram_top.sv
verif/tb_chan_if.sv
verif/tb_top.sv
